>>> src/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// types, constants and helper functions shared by the ray/box slab test block
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int COORD_BITS = 16;
  localparam int AXES       = 3;
  localparam int SLOTS      = 4;
  localparam int FRAC_BITS  = 8;
  localparam int CORNER_W   = COORD_BITS + 1;
  localparam int PROD_W     = COORD_BITS + CORNER_W;
  localparam int TRANS_W    = COORD_BITS + FRAC_BITS;
  localparam int BND_W      = PROD_W + 2;
  localparam int DIFF_W     = BND_W + 1;
  localparam int NUM_W      = DIFF_W + FRAC_BITS;
  localparam int DIV_DIGITS = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int DQ_W       = DIV_STAGES * DIV_DIGITS;
  localparam int QUOTS      = 2 * AXES;
  localparam int DIST_W     = 32;
  localparam int T_W        = DIST_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int BOX_W      = AXES * COORD_BITS;
  localparam int MID_DEPTH  = 4;
  localparam int MID_PTR_W  = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH  = 2;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

  localparam logic [CFG_DATA_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
  localparam logic [CFG_DATA_W-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;
  localparam logic signed [T_W-1:0] T_LIMIT     = 34'sh0_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_CENTER = 3'd0,
    REG_BOX_HALF   = 3'd1,
    REG_ROW_X      = 3'd2,
    REG_ROW_Y      = 3'd3,
    REG_ROW_Z      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] entry_dist;
  } res_t;

  typedef struct packed {
    logic [AXES-1:0][BND_W-1:0] wmin;
    logic [AXES-1:0][BND_W-1:0] wmax;
  } bounds_t;

  typedef struct packed {
    logic [AXES-1:0][DIFF_W-1:0]     diff_lo;
    logic [AXES-1:0][DIFF_W-1:0]     diff_hi;
    logic [AXES-1:0][COORD_BITS-1:0] dir;
    logic [AXES-1:0]                 dir_zero;
    logic                            zmiss;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [QUOTS-1:0]      neg;
    logic [AXES-1:0]       dir_zero;
    logic                  zmiss;
  } side_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] rem;
    logic [DQ_W-1:0]       dq;
  } div_t;

  // four restoring division steps
  function automatic div_t div_step(logic [COORD_BITS-1:0] rem, logic [DQ_W-1:0] dq,
                                    logic [COORD_BITS-1:0] d);
    div_t              r;
    logic [COORD_BITS:0] acc;
    r.rem = rem;
    r.dq  = dq;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      acc  = {r.rem, r.dq[DQ_W-1]};
      r.dq = {r.dq[DQ_W-2:0], 1'b0};
      if (acc >= {1'b0, d}) begin
        acc     = acc - {1'b0, d};
        r.dq[0] = 1'b1;
      end
      r.rem = acc[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // signed distance, negatives folded to -1, large values saturated
  function automatic logic signed [T_W-1:0] t_clamp(logic [DQ_W-1:0] mag, logic neg);
    logic signed [T_W-1:0] t;
    if (neg && (mag != '0)) begin
      t = -34'sd1;
    end else if (mag > DQ_W'(T_LIMIT)) begin
      t = T_LIMIT;
    end else begin
      t = {2'b00, mag[DIST_W-1:0]};
    end
    return t;
  endfunction

endpackage

>>> src/rbsi_bounds.sv
// ----------------------------------------------------------------------------
// rbsi_bounds
// box registers and transform of both corners into world bounds
// ----------------------------------------------------------------------------
module rbsi_bounds (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rbsi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rbsi_pkg::bounds_t               bounds_o
);
  import rbsi_pkg::*;

  logic [BOX_W-1:0]      center_q;
  logic [BOX_W-1:0]      half_q;
  logic [CFG_DATA_W-1:0] row_q [AXES];

  logic signed [CORNER_W-1:0] lo   [AXES];
  logic signed [CORNER_W-1:0] hi   [AXES];
  logic signed [PROD_W-1:0]   pl   [AXES][AXES];
  logic signed [PROD_W-1:0]   ph   [AXES][AXES];
  logic signed [PROD_W-1:0]   pl_q [AXES][AXES];
  logic signed [PROD_W-1:0]   ph_q [AXES][AXES];
  logic signed [TRANS_W-1:0]  tr_q [AXES];
  logic signed [BND_W-1:0]    sa   [AXES];
  logic signed [BND_W-1:0]    sb   [AXES];
  bounds_t                    bounds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      half_q   <= '0;
      row_q[0] <= ROW_X_RESET;
      row_q[1] <= ROW_Y_RESET;
      row_q[2] <= ROW_Z_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BOX_CENTER: center_q <= cfg_data_i[BOX_W-1:0];
        REG_BOX_HALF:   half_q   <= cfg_data_i[BOX_W-1:0];
        REG_ROW_X:      row_q[0] <= cfg_data_i;
        REG_ROW_Y:      row_q[1] <= cfg_data_i;
        REG_ROW_Z:      row_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      lo[k] = CORNER_W'($signed(center_q[k*COORD_BITS +: COORD_BITS]))
            - CORNER_W'($signed(half_q[k*COORD_BITS +: COORD_BITS]));
      hi[k] = CORNER_W'($signed(center_q[k*COORD_BITS +: COORD_BITS]))
            + CORNER_W'($signed(half_q[k*COORD_BITS +: COORD_BITS]));
    end
    for (int r = 0; r < AXES; r++) begin
      for (int j = 0; j < AXES; j++) begin
        pl[r][j] = PROD_W'($signed(row_q[r][j*COORD_BITS +: COORD_BITS])) * PROD_W'(lo[j]);
        ph[r][j] = PROD_W'($signed(row_q[r][j*COORD_BITS +: COORD_BITS])) * PROD_W'(hi[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl;
    ph_q <= ph;
    for (int r = 0; r < AXES; r++) begin
      tr_q[r] <= {row_q[r][(SLOTS-1)*COORD_BITS +: COORD_BITS], {FRAC_BITS{1'b0}}};
    end
  end

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      sa[r] = BND_W'(tr_q[r]) + BND_W'(pl_q[r][0]) + BND_W'(pl_q[r][1]) + BND_W'(pl_q[r][2]);
      sb[r] = BND_W'(tr_q[r]) + BND_W'(ph_q[r][0]) + BND_W'(ph_q[r][1]) + BND_W'(ph_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < AXES; r++) begin
      bounds_q.wmin[r] <= (sa[r] < sb[r]) ? sa[r] : sb[r];
      bounds_q.wmax[r] <= (sa[r] < sb[r]) ? sb[r] : sa[r];
    end
  end

  assign bounds_o = bounds_q;

endmodule

>>> src/rbsi_front.sv
// ----------------------------------------------------------------------------
// rbsi_front
// accepts rays, forms slab numerators and sorts out parallel axes
// ----------------------------------------------------------------------------
module rbsi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rbsi_pkg::ray_t    ray_i,
  output logic              full_o,
  input  rbsi_pkg::bounds_t bounds_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output rbsi_pkg::job_t    q_data_o
);
  import rbsi_pkg::*;

  logic en;
  logic f1_valid_q, f2_valid_q;
  ray_t f1_ray_q, f2_ray_q;

  logic signed [COORD_BITS-1:0] dir [AXES];
  logic signed [DIFF_W-1:0]     org [AXES];
  logic signed [DIFF_W-1:0]     wmn [AXES];
  logic signed [DIFF_W-1:0]     wmx [AXES];

  assign en       = !(f2_valid_q && q_full_i);
  assign full_o   = !en;
  assign q_push_o = f2_valid_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= push_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_ray_q <= ray_i;
      f2_ray_q <= f1_ray_q;
    end
  end

  always_comb begin
    dir[0] = f2_ray_q.dir_x;
    dir[1] = f2_ray_q.dir_y;
    dir[2] = f2_ray_q.dir_z;
    org[0] = DIFF_W'($signed({f2_ray_q.origin_x, {FRAC_BITS{1'b0}}}));
    org[1] = DIFF_W'($signed({f2_ray_q.origin_y, {FRAC_BITS{1'b0}}}));
    org[2] = DIFF_W'($signed({f2_ray_q.origin_z, {FRAC_BITS{1'b0}}}));
    q_data_o.zmiss = 1'b0;
    for (int k = 0; k < AXES; k++) begin
      wmn[k] = DIFF_W'($signed(bounds_i.wmin[k]));
      wmx[k] = DIFF_W'($signed(bounds_i.wmax[k]));
      q_data_o.diff_lo[k]  = wmn[k] - org[k];
      q_data_o.diff_hi[k]  = wmx[k] - org[k];
      q_data_o.dir[k]      = dir[k];
      q_data_o.dir_zero[k] = (dir[k] == '0);
      if ((dir[k] == '0) && ((org[k] < wmn[k]) || (org[k] > wmx[k]))) begin
        q_data_o.zmiss = 1'b1;
      end
    end
  end

endmodule

>>> src/rbsi_queue.sv
// ----------------------------------------------------------------------------
// rbsi_queue
// short queue of classified rays between front and back
// ----------------------------------------------------------------------------
module rbsi_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rbsi_pkg::job_t        data_i,
  input  logic                  pop_i,
  output rbsi_pkg::job_t        data_o,
  output rbsi_pkg::queue_stat_t stat_o
);
  import rbsi_pkg::*;

  job_t                 mem_q [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [MID_PTR_W:0]   count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (MID_PTR_W+1)'(MID_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

>>> src/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// pipelined restoring divider, four quotient bits per stage
// ----------------------------------------------------------------------------
module rbsi_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [rbsi_pkg::DQ_W-1:0]       dividend_i,
  input  logic [rbsi_pkg::COORD_BITS-1:0] divisor_i,
  output logic [rbsi_pkg::DQ_W-1:0]       quotient_o
);
  import rbsi_pkg::*;

  div_t                  st_d [DIV_STAGES];
  div_t                  st_q [DIV_STAGES];
  logic [COORD_BITS-1:0] d_q  [DIV_STAGES-1];

  always_comb begin
    st_d[0] = div_step('0, dividend_i, divisor_i);
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_d[s] = div_step(st_q[s-1].rem, st_q[s-1].dq, d_q[s-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q   <= st_d;
      d_q[0] <= divisor_i;
      for (int s = 1; s < DIV_STAGES-1; s++) begin
        d_q[s] <= d_q[s-1];
      end
    end
  end

  assign quotient_o = st_q[DIV_STAGES-1].dq;

endmodule

>>> src/rbsi_back.sv
// ----------------------------------------------------------------------------
// rbsi_back
// slab distances, interval narrowing and result queue
// ----------------------------------------------------------------------------
module rbsi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rbsi_pkg::job_t job_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rbsi_pkg::res_t result_o
);
  import rbsi_pkg::*;

  logic en, out_full, out_wr, out_rd;

  logic                  b0_valid_q;
  logic [DIV_STAGES-1:0] valid_q;
  logic                  p1_valid_q;
  side_t                 b0_side_q;
  logic [DQ_W-1:0]       b0_num_q [QUOTS];
  logic [COORD_BITS-1:0] b0_den_q [AXES];
  side_t                 side_q   [DIV_STAGES];
  logic [DQ_W-1:0]       quot     [QUOTS];
  side_t                 p1_side_q;
  logic signed [T_W-1:0] p1_t_q   [QUOTS];

  logic signed [DIFF_W-1:0]     diff [QUOTS];
  logic signed [COORD_BITS-1:0] dsg  [AXES];
  logic [DIFF_W-1:0]            dmag [QUOTS];
  logic signed [T_W-1:0]        tmin, tmax, tl, th;
  res_t                         res;

  res_t                 out_mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wr_q, out_rd_q;
  logic [OUT_PTR_W:0]   out_cnt_q;

  assign out_rd   = pop_i && (out_cnt_q != '0);
  assign out_full = (out_cnt_q == (OUT_PTR_W+1)'(OUT_DEPTH)) && !out_rd;
  assign en       = !(p1_valid_q && out_full);
  assign q_pop_o  = en && !q_empty_i;
  assign out_wr   = en && p1_valid_q;

  // magnitudes and signs for the dividers
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      diff[2*k]   = $signed(job_i.diff_lo[k]);
      diff[2*k+1] = $signed(job_i.diff_hi[k]);
      dsg[k]      = $signed(job_i.dir[k]);
    end
    for (int i = 0; i < QUOTS; i++) begin
      dmag[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_valid_q <= 1'b0;
      valid_q    <= '0;
      p1_valid_q <= 1'b0;
    end else if (en) begin
      b0_valid_q <= q_pop_o;
      valid_q    <= {valid_q[DIV_STAGES-2:0], b0_valid_q};
      p1_valid_q <= valid_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_side_q.dir_zero <= job_i.dir_zero;
      b0_side_q.zmiss    <= job_i.zmiss;
      for (int i = 0; i < QUOTS; i++) begin
        b0_num_q[i]      <= DQ_W'({dmag[i], {FRAC_BITS{1'b0}}});
        b0_side_q.neg[i] <= diff[i][DIFF_W-1] ^ dsg[i/2][COORD_BITS-1];
      end
      for (int k = 0; k < AXES; k++) begin
        b0_den_q[k] <= dsg[k][COORD_BITS-1] ? COORD_BITS'(-dsg[k]) : COORD_BITS'(dsg[k]);
      end
      side_q[0] <= b0_side_q;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
      p1_side_q <= side_q[DIV_STAGES-1];
      for (int i = 0; i < QUOTS; i++) begin
        p1_t_q[i] <= t_clamp(quot[i], side_q[DIV_STAGES-1].neg[i]);
      end
    end
  end

  for (genvar g = 0; g < QUOTS; g++) begin : gen_div
    rbsi_div u_div (
      .clk_i      (clk_i),
      .en_i       (en),
      .dividend_i (b0_num_q[g]),
      .divisor_i  (b0_den_q[g/2]),
      .quotient_o (quot[g])
    );
  end

  // narrow the interval over non-parallel axes
  always_comb begin
    tmin = '0;
    tmax = T_LIMIT;
    for (int k = 0; k < AXES; k++) begin
      tl = (p1_t_q[2*k] > p1_t_q[2*k+1]) ? p1_t_q[2*k+1] : p1_t_q[2*k];
      th = (p1_t_q[2*k] > p1_t_q[2*k+1]) ? p1_t_q[2*k]   : p1_t_q[2*k+1];
      if (!p1_side_q.dir_zero[k]) begin
        if (tl > tmin) tmin = tl;
        if (th < tmax) tmax = th;
      end
    end
    res.hit        = !p1_side_q.zmiss && !(tmin > tmax);
    res.entry_dist = res.hit ? tmin[DIST_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (out_wr) out_wr_q <= out_wr_q + 1'b1;
      if (out_rd) out_rd_q <= out_rd_q + 1'b1;
      if (out_wr && !out_rd) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end else if (out_rd && !out_wr) begin
        out_cnt_q <= out_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) out_mem_q[out_wr_q] <= res;
  end

  assign empty_o  = (out_cnt_q == '0);
  assign result_o = out_mem_q[out_rd_q];

endmodule

>>> src/ray_box_slab_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top
// ray against affine-transformed box, slab test in fixed point
// ----------------------------------------------------------------------------
// Takes one ray per cycle while full is low and returns one result item per
// ray, in order. The box corners are transformed from the configuration
// registers ahead of time, so a ray only pays for the slab test: two front
// stages, a four-entry queue, a magnitude stage, eleven divider stages (four
// quotient bits each, six dividers in parallel), a clamp stage and a two-entry
// result queue. Throughput stays one ray per cycle when nothing stalls.
// Configuration writes are always taken and must only be made while idle.
module ray_box_slab_intersect_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  rbsi_pkg::ray_t                  ray_i,
  output logic                            empty,
  input  logic                            pop,
  output rbsi_pkg::res_t                  result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rbsi_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rbsi_pkg::*;

  bounds_t     bounds;
  job_t        front_job, mid_job;
  queue_stat_t mid_stat;
  logic        mid_push, mid_pop, mid_full;

  assign cfg_ready_o = 1'b1;
  assign mid_full    = mid_stat.full && !mid_pop;

  rbsi_bounds u_bounds (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bounds_o    (bounds)
  );

  rbsi_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .ray_i    (ray_i),
    .full_o   (full),
    .bounds_i (bounds),
    .q_full_i (mid_full),
    .q_push_o (mid_push),
    .q_data_o (front_job)
  );

  rbsi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (front_job),
    .pop_i  (mid_pop),
    .data_o (mid_job),
    .stat_o (mid_stat)
  );

  rbsi_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (mid_job),
    .q_empty_i (mid_stat.empty),
    .q_pop_o   (mid_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.hit) |-> (result_o.entry_dist == '0))
    else $error("miss with nonzero entry distance");

  a_mid_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_stat.full |-> !mid_stat.empty)
    else $error("queue both full and empty");

  a_mid_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_stat.empty)
    else $error("back took an item from an empty queue");

  a_mid_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> (!mid_stat.full || mid_pop))
    else $error("front wrote into a full queue");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// rays against a configured, affine-transformed box: each result item is
// checked against a slab-test predictor across a series of box settings
// ----------------------------------------------------------------------------
module testbench;
  import rbsi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 3'd5;
  localparam longint DIST_MAX  = 64'h0000_0000_FFFF_FFFF;
  localparam int     STALL_MAX = 5000;
  localparam int     DRAIN     = 40;

  typedef struct {
    ray_t ray;
    bit   known;
    res_t want;
  } ray_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  ray_t ray_i = '0;
  logic empty;
  logic pop = 1'b0;
  res_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [BOX_W-1:0]      box_center;
  logic [BOX_W-1:0]      box_half;
  logic [CFG_DATA_W-1:0] xform_row [AXES];

  res_t   pending_res [$];
  int     errors = 0;
  int     n_rays = 0;
  int     n_results = 0;
  int     n_hits = 0;
  int     stall_cycles = 0;
  bit     steady = 1'b0;

  ray_box_slab_intersect_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint coord(logic [CFG_DATA_W-1:0] v, int k);
    logic signed [COORD_BITS-1:0] s;
    s = v[k*COORD_BITS +: COORD_BITS];
    return longint'(s);
  endfunction

  function automatic longint slab_dist(longint num, longint d);
    longint q;
    q = (num * 256) / d;
    return (q > DIST_MAX) ? DIST_MAX : q;
  endfunction

  function automatic res_t slab_hit(ray_t r);
    longint lo [AXES], hi [AXES], a [AXES], b [AXES], org [AXES], dir [AXES];
    longint wmin, wmax, t1, t2, s, tmin, tmax;
    logic signed [COORD_BITS-1:0] o [AXES], d [AXES];
    bit hit;
    res_t res;
    o = '{r.origin_x, r.origin_y, r.origin_z};
    d = '{r.dir_x, r.dir_y, r.dir_z};
    tmin = 0;
    tmax = DIST_MAX;
    hit = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      lo[i]  = coord(box_center, i) - coord(box_half, i);
      hi[i]  = coord(box_center, i) + coord(box_half, i);
      org[i] = longint'(o[i]) * 256;
      dir[i] = longint'(d[i]);
    end
    for (int i = 0; i < AXES; i++) begin
      a[i] = coord(xform_row[i], 3) * 256;
      b[i] = a[i];
      for (int j = 0; j < AXES; j++) begin
        a[i] += coord(xform_row[i], j) * lo[j];
        b[i] += coord(xform_row[i], j) * hi[j];
      end
    end
    for (int i = 0; i < AXES && hit; i++) begin
      wmin = (a[i] < b[i]) ? a[i] : b[i];
      wmax = (a[i] < b[i]) ? b[i] : a[i];
      if (dir[i] == 0) begin
        if (org[i] < wmin || org[i] > wmax) hit = 1'b0;
      end else begin
        t1 = slab_dist(wmin - org[i], dir[i]);
        t2 = slab_dist(wmax - org[i], dir[i]);
        if (t1 > t2) begin
          s  = t1;
          t1 = t2;
          t2 = s;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax) hit = 1'b0;
      end
    end
    res.hit        = hit;
    res.entry_dist = hit ? tmin[DIST_W-1:0] : '0;
    return res;
  endfunction

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 11);
  endfunction

  // accepted item leaves the sender at the edge where push is high and full low
  task automatic send_ray(ray_t r, bit known = 1'b0, res_t want = '0);
    while (idle_now()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    ray_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_res.push_back(known ? want : slab_hit(r));
    n_rays++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // leaves valid high; the caller drops it once the last write is taken
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_BOX_CENTER: box_center = data[BOX_W-1:0];
      REG_BOX_HALF:   box_half   = data[BOX_W-1:0];
      REG_ROW_X:      xform_row[0] = data;
      REG_ROW_Y:      xform_row[1] = data;
      REG_ROW_Z:      xform_row[2] = data;
      default: ;
    endcase
  endtask

  task automatic load_box(logic [BOX_W-1:0] c, logic [BOX_W-1:0] h,
                          logic [CFG_DATA_W-1:0] rx, logic [CFG_DATA_W-1:0] ry,
                          logic [CFG_DATA_W-1:0] rz);
    wait_drained();
    write_reg(REG_BOX_CENTER, {16'h0, c});
    write_reg(REG_BOX_HALF, {16'h0, h});
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] small_coord(int span);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    logic [15:0] o [AXES], d [AXES];
    if ($urandom_range(3) == 0) begin
      r = {$urandom, $urandom, $urandom};
    end else begin
      for (int i = 0; i < AXES; i++) begin
        o[i] = small_coord(16'h0C00);
        d[i] = 16'(-$signed(o[i]) >>> $urandom_range(3)) + small_coord(16'h0040);
        if ($urandom_range(7) == 0) d[i] = '0;
      end
      r = '{o[0], o[1], o[2], d[0], d[1], d[2]};
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_res.size() == 0) begin
          $display("%0t unexpected result item: hit %0b dist %h", $time,
                   result_o.hit, result_o.entry_dist);
          errors++;
        end else begin
          res_t w;
          w = pending_res.pop_front();
          if (w.hit !== result_o.hit) begin
            $display("%0t hit: expected %0b actual %0b", $time, w.hit, result_o.hit);
            errors++;
          end
          if (w.entry_dist !== result_o.entry_dist) begin
            $display("%0t entry_dist: expected %h actual %h", $time,
                     w.entry_dist, result_o.entry_dist);
            errors++;
          end
          n_results++;
          if (result_o.hit) n_hits++;
        end
      end
      pop <= !idle_now();
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  ray_row_t at_reset [] = '{
    '{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, '{1'b1, 32'h0}},
    '{'{16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, '{1'b0, 32'h0}},
    '{'{16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0}, 1'b1, '{1'b1, 32'h0}},
    '{'{16'hFF00, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0}, 1'b1, '{1'b1, 32'h0001_0000}},
    '{'{16'h8000, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0}, 1'b1, '{1'b0, 32'h0}}
  };

  ray_row_t unit_box [] = '{
    '{'{16'h0080, 16'hFF80, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{16'h0300, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{16'hFD00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{16'h0500, 16'h0010, 16'h0, 16'hFF00, 16'h0, 16'h0}, 1'b0, '0},
    '{'{16'hFB00, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0}, 1'b0, '0},
    '{'{16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0100}, 1'b0, '0},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
    '{'{16'h8000, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0}, 1'b0, '0},
    '{'{16'h7FFF, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0}, 1'b0, '0},
    '{'{16'hFA00, 16'hFA00, 16'h0, 16'h0100, 16'h0010, 16'h0}, 1'b0, '0},
    '{'{16'hFA00, 16'h0, 16'hFA00, 16'h0100, 16'h0, 16'h0400}, 1'b0, '0},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
  };

  initial begin
    box_center   = '0;
    box_half     = '0;
    xform_row[0] = ROW_X_RESET;
    xform_row[1] = ROW_Y_RESET;
    xform_row[2] = ROW_Z_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (at_reset[i]) send_ray(at_reset[i].ray, at_reset[i].known, at_reset[i].want);

    // unit box, identity transform, then a write to an unused index
    load_box({3{16'h0100}}, {3{16'h0100}}, ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET);
    write_reg(REG_UNLISTED, '1);
    cfg_valid_i <= 1'b0;
    foreach (unit_box[i]) send_ray(unit_box[i].ray);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_box({3{16'h0400}}, {3{16'h0400}}, ROW_X_RESET, ROW_Y_RESET,
                    ROW_Z_RESET);
        1: load_box({small_coord(16'h0800), small_coord(16'h0800), small_coord(16'h0800)},
                    {small_coord(16'h0800), small_coord(16'h0800), small_coord(16'h0800)},
                    {small_coord(16'h0100), 32'h0, small_coord(16'h0180)},
                    {small_coord(16'h0100), 16'h0, small_coord(16'h0180), 16'h0},
                    {small_coord(16'h0100), small_coord(16'h0180), 32'h0});
        2: load_box('1, '1, '1, '1, '1);
        3: load_box({3{16'h7FFF}}, {3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                    {4{16'h7FFF}});
        4: load_box({3{16'h8000}}, {3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                    {4{16'h8000}});
        default: load_box(BOX_W'({$urandom, $urandom}), BOX_W'({$urandom, $urandom}),
                          {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom});
      endcase
      steady = (ph == 1);
      for (int k = 0; k < 200; k++) begin
        if (ph == 3 && k == 100) begin
          push <= 1'b0;
          @(posedge clk_i);
          while (pending_res.size() != 0) @(posedge clk_i);
        end
        send_ray(random_ray());
      end
      steady = 1'b0;
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("rays sent %0d, results checked %0d (hits %0d) over 10 box settings",
             n_rays, n_results, n_hits);
    $display("settings covered reset, unit box, extremes and random transforms");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/rbsi_pkg.sv
src/rbsi_bounds.sv
src/rbsi_front.sv
src/rbsi_queue.sv
src/rbsi_div.sv
src/rbsi_back.sv
src/ray_box_slab_intersect_top.sv
sim/testbench.sv
